@@ sv/prf_pkg.sv @@
// Shared types, constants and helpers for the pulse region finder.
`default_nettype none

package prf_pkg;

    localparam int TICK_OUT_W = 14;
    localparam int CNT_W      = 2;
    localparam int THR_W      = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0] CNT_SINGLE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MERGED = CNT_W'(2);

    typedef struct packed {
        logic [TICK_OUT_W-1:0] begin_tick;
        logic [TICK_OUT_W-1:0] finish_tick;
        logic [TICK_OUT_W-1:0] first_peak_tick;
        logic [TICK_OUT_W-1:0] second_peak_tick;
        logic [CNT_W-1:0]      peak_count;
        logic                  last_of_run;
    } t_record;

    // up to two records produced by one sample, in order
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_record r0;
        t_record r1;
    } t_push;

    function automatic t_record make_rec(
        input logic [TICK_OUT_W-1:0] s,
        input logic [TICK_OUT_W-1:0] e,
        input logic [TICK_OUT_W-1:0] p1,
        input logic [TICK_OUT_W-1:0] p2,
        input logic [CNT_W-1:0]      cnt
    );
        t_record r;
        r.begin_tick       = s;
        r.finish_tick      = e;
        r.first_peak_tick  = p1;
        r.second_peak_tick = p2;
        r.peak_count       = cnt;
        r.last_of_run      = 1'b0;
        return r;
    endfunction

    function automatic t_push push_rec(input t_push p, input t_record r);
        t_push q;
        q = p;
        if (!q.v0) begin
            q.v0 = 1'b1;
            q.r0 = r;
        end else begin
            q.v1 = 1'b1;
            q.r1 = r;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ sv/prf_core.sv @@
// Window check, pulse open/close/merge state and record generation.
`default_nettype none

module prf_core #(
    parameter int MAX_TICKS   = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [prf_pkg::THR_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_adv,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                         i_last,
    output prf_pkg::t_push                    o_push
);
    import prf_pkg::*;

    localparam int TW = $clog2(MAX_TICKS);
    localparam int CW = SAMPLE_BITS + 17;
    localparam logic [TW-1:0] TICK_MAX = TW'(MAX_TICKS - 1);

    function automatic logic [TICK_OUT_W-1:0] tick_out(input logic [TW-1:0] t);
        logic [TW+TICK_OUT_W-1:0] ext;
        ext = {{TICK_OUT_W{1'b0}}, t};
        return ext[TICK_OUT_W-1:0];
    endfunction

    logic [THR_W-1:0]              r_thr;
    logic signed [SAMPLE_BITS-1:0] r_w0, r_w1, r_pes, n_pes;
    logic [TW-1:0]                 r_tick, n_tick;
    logic                          r_open, n_open;
    logic [TW-1:0]                 r_held, n_held;
    logic [TW-1:0]                 r_os, n_os, r_op, n_op;
    logic [TW-1:0]                 r_ps, n_ps, r_pe, n_pe, r_pp, n_pp;
    logic                          r_pv, n_pv, r_pm, n_pm;

    logic signed [CW-1:0] xa, xb, xx, xthr, xes2;
    logic [TW-1:0]        c;
    logic                 has_win, is_min, is_max, merge_ok;
    t_push                psh;

    always_comb begin
        xa      = CW'(r_w0);
        xb      = CW'(r_w1);
        xx      = CW'(i_sample);
        xthr    = {{(CW-THR_W){1'b0}}, r_thr};
        xes2    = CW'(r_pes) <<< 1;
        c       = r_tick - TW'(1);
        has_win = (r_tick > TW'(1));
        is_min  = (xb < xa) && (xb < xx);
        is_max  = (xb > xa) && (xb > xx) && (xb > xthr);
        merge_ok = ({1'b0, r_held} < ({1'b0, r_pe} + (TW+1)'(2))) && (xes2 > xthr);
    end

    always_comb begin
        n_open = r_open;
        n_held = r_held;
        n_os   = r_os;
        n_op   = r_op;
        n_ps   = r_ps;
        n_pe   = r_pe;
        n_pp   = r_pp;
        n_pes  = r_pes;
        n_pv   = r_pv;
        n_pm   = r_pm;
        psh    = '0;

        if (has_win) begin
            if (is_min) begin
                if (r_open) begin
                    n_open = 1'b0;
                    if (r_pv && r_pm) begin
                        psh  = push_rec(psh, make_rec(tick_out(r_ps), tick_out(c),
                                        tick_out(r_pp), tick_out(r_op), CNT_MERGED));
                        n_pv = 1'b0;
                        n_pm = 1'b0;
                    end else begin
                        n_pv  = 1'b1;
                        n_pm  = 1'b0;
                        n_ps  = r_os;
                        n_pe  = c;
                        n_pp  = r_op;
                        n_pes = r_w1;
                    end
                    n_held = r_tick;
                end else begin
                    n_held = c;
                end
            end else if (is_max && !r_open) begin
                if (r_pv && !r_pm) begin
                    if (merge_ok) begin
                        n_pm = 1'b1;
                    end else begin
                        psh  = push_rec(psh, make_rec(tick_out(r_ps), tick_out(r_pe),
                                        tick_out(r_pp), '0, CNT_SINGLE));
                        n_pv = 1'b0;
                    end
                end
                n_open = 1'b1;
                n_os   = r_held;
                n_op   = c;
            end
        end

        // end of wire: close the open pulse, flush the pending one
        if (i_last) begin
            if (n_open) begin
                if (n_pv && n_pm) begin
                    psh  = push_rec(psh, make_rec(tick_out(n_ps), tick_out(r_tick),
                                    tick_out(n_pp), tick_out(n_op), CNT_MERGED));
                    n_pv = 1'b0;
                end else begin
                    n_pv = 1'b1;
                    n_ps = n_os;
                    n_pe = r_tick;
                    n_pp = n_op;
                end
            end
            if (n_pv) begin
                psh = push_rec(psh, make_rec(tick_out(n_ps), tick_out(n_pe),
                                tick_out(n_pp), '0, CNT_SINGLE));
            end
        end

        if (psh.v1) begin
            psh.r1.last_of_run = 1'b1;
        end else if (psh.v0) begin
            psh.r0.last_of_run = 1'b1;
        end

        n_tick = (r_tick < TICK_MAX) ? r_tick + TW'(1) : r_tick;
    end

    always_comb begin
        o_push    = psh;
        o_push.v0 = psh.v0 & i_adv;
        o_push.v1 = psh.v1 & i_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_w0   <= '0;
            r_w1   <= '0;
            r_tick <= '0;
            r_open <= 1'b0;
            r_held <= '0;
            r_os   <= '0;
            r_op   <= '0;
            r_ps   <= '0;
            r_pe   <= '0;
            r_pp   <= '0;
            r_pes  <= '0;
            r_pv   <= 1'b0;
            r_pm   <= 1'b0;
        end else if (i_adv) begin
            r_w0   <= r_w1;
            r_w1   <= i_sample;
            r_tick <= n_tick;
            r_open <= n_open;
            r_held <= n_held;
            r_os   <= n_os;
            r_op   <= n_op;
            r_ps   <= n_ps;
            r_pe   <= n_pe;
            r_pp   <= n_pp;
            r_pes  <= n_pes;
            r_pv   <= n_pv;
            r_pm   <= n_pm;
        end
    end

endmodule

`default_nettype wire

@@ sv/prf_fifo.sv @@
// Result queue: takes up to two records a cycle, delivers one a beat.
`default_nettype none

module prf_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire prf_pkg::t_push   i_push,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output prf_pkg::t_record      o_rec
);
    import prf_pkg::*;

    t_record            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;
    logic [PTR_W-1:0]   wr_nxt;
    logic               pop;
    logic [PTR_W:0]     n_push;

    assign wr_nxt  = r_wr + PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_cnt <= (PTR_W+1)'(FIFO_DEPTH - 2));
    assign n_push  = (PTR_W+1)'(i_push.v0) + (PTR_W+1)'(i_push.v1);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_nxt] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_push[PTR_W-1:0];
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + n_push - (PTR_W+1)'(pop);
        end
    end

endmodule

`default_nettype wire

@@ sv/pulse_region_finder.sv @@
// Pulse region finder: input register, pulse logic and result queue.
//
// Input channel (i_valid / o_stall): one signed sample of a wire per beat,
// with i_last_sample on the final sample of the wire. Output channel
// (o_valid / i_stall): one pulse record per beat; o_last_of_run marks the
// last record caused by a given sample. A sample causes zero, one or two
// records.
// A sample is taken into the input register when accepted; the pulse logic
// works on it combinationally and writes its records into the result queue
// at an edge where the queue has room; the queue head drives the outputs.
// Throughput is one sample per clock while the receiver takes records as
// fast as they come; the four-entry result queue sets the limit: a sample
// moves on only while the queue has room for two records, else o_stall rises.
// A stalled receiver fills the queue and then holds off the input; the
// record at the head stays unchanged while stalled.
// Synchronous reset clears the threshold to zero, the wire state and the
// queue. i_cfg_we writes the threshold; write it only while idle. After the
// final sample of a wire the wire state returns to reset by itself.
`default_nettype none

module pulse_region_finder #(
    parameter int MAX_TICKS   = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  wire logic                           i_last_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [prf_pkg::THR_W-1:0]      i_cfg_wdata,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [prf_pkg::TICK_OUT_W-1:0]      o_begin_tick,
    output logic [prf_pkg::TICK_OUT_W-1:0]      o_finish_tick,
    output logic [prf_pkg::TICK_OUT_W-1:0]      o_first_peak_tick,
    output logic [prf_pkg::TICK_OUT_W-1:0]      o_second_peak_tick,
    output logic [prf_pkg::CNT_W-1:0]           o_peak_count,
    output logic                                o_last_of_run
);
    import prf_pkg::*;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_last;
    logic                          room, adv, accept;
    t_push                         push;
    t_record                       rec;

    assign adv     = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_sample;
            r_in_last   <= i_last_sample;
        end
    end

    prf_core #(
        .MAX_TICKS   (MAX_TICKS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_sample    (r_in_sample),
        .i_last      (r_in_last),
        .o_push      (push)
    );

    prf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (rec)
    );

    assign o_begin_tick       = rec.begin_tick;
    assign o_finish_tick      = rec.finish_tick;
    assign o_first_peak_tick  = rec.first_peak_tick;
    assign o_second_peak_tick = rec.second_peak_tick;
    assign o_peak_count       = rec.peak_count;
    assign o_last_of_run      = rec.last_of_run;

endmodule

`default_nettype wire

@@ sv/prf_checker.sv @@
// Port-level checks for the pulse region finder, bound to the top level.
`default_nettype none

module prf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [13:0] o_second_peak_tick,
    input wire logic [1:0]  o_peak_count
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled output beat dropped");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_count == 2'd1) || (o_peak_count == 2'd2))
        else $error("peak count out of range");

    a_single_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_peak_count == 2'd1) |-> o_second_peak_tick == 14'd0)
        else $error("single-peak record carries a second peak");

endmodule

bind pulse_region_finder prf_checker u_prf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_second_peak_tick (o_second_peak_tick),
    .o_peak_count       (o_peak_count)
);

`default_nettype wire

@@ sim/pulse_region_finder_tb.sv @@
// Self-checking testbench for the pulse region finder: directed wires, a long wire, random wires.
`timescale 1ns / 1ps

module pulse_region_finder_tb;
    import prf_pkg::*;

    localparam int MAX_TICKS   = 16384;
    localparam int SAMPLE_BITS = 16;
    localparam int LIMIT       = 600000;
    localparam int PHASE_ITEMS = 250;
    localparam int LONG_LEN    = 650;

    class pulse_book;
        t_record  due_records[$];
        t_record  fresh[$];
        int       errors;
        int       thr;
        int       win[2];
        int       tick;
        bit       is_open;
        int       held;
        int       open_s;
        int       open_p;
        int       pend_s;
        int       pend_e;
        int       pend_p;
        int       pend_es;
        bit       pend_v;
        bit       pend_m;
        string    field_name[6] = '{"begin_tick", "finish_tick", "first_peak_tick",
                                    "second_peak_tick", "peak_count", "last_of_run"};

        function void clear_wire();
            win     = '{0, 0};
            tick    = 0;
            is_open = 1'b0;
            held    = 0;
            open_s  = 0;
            open_p  = 0;
            pend_s  = 0;
            pend_e  = 0;
            pend_p  = 0;
            pend_es = 0;
            pend_v  = 1'b0;
            pend_m  = 1'b0;
        endfunction

        function void add_record(int s, int e, int p1, int p2, logic [CNT_W-1:0] cnt);
            t_record r;
            r.begin_tick       = s[TICK_OUT_W-1:0];
            r.finish_tick      = e[TICK_OUT_W-1:0];
            r.first_peak_tick  = p1[TICK_OUT_W-1:0];
            r.second_peak_tick = p2[TICK_OUT_W-1:0];
            r.peak_count       = cnt;
            r.last_of_run      = 1'b0;
            fresh.insert(fresh.size(), r);
        endfunction

        function void close_pulse(int e, int es);
            is_open = 1'b0;
            if (pend_v && pend_m) begin
                add_record(pend_s, e, pend_p, open_p, CNT_MERGED);
                pend_v = 1'b0;
                pend_m = 1'b0;
            end else begin
                pend_v  = 1'b1;
                pend_m  = 1'b0;
                pend_s  = open_s;
                pend_e  = e;
                pend_p  = open_p;
                pend_es = es;
            end
        endfunction

        function void open_pulse(int c);
            if (pend_v && !pend_m) begin
                if (held < pend_e + 2 && 2 * pend_es > thr) begin
                    pend_m = 1'b1;
                end else begin
                    add_record(pend_s, pend_e, pend_p, 0, CNT_SINGLE);
                    pend_v = 1'b0;
                end
            end
            is_open = 1'b1;
            open_s  = held;
            open_p  = c;
        endfunction

        function void take_sample(int x, bit last);
            int t;
            int a;
            int b;
            int c;
            fresh.delete();
            t = tick;
            a = win[0];
            b = win[1];
            c = t - 1;
            if (t >= 2) begin
                if (b < a && b < x) begin
                    if (is_open) begin
                        close_pulse(c, b);
                        held = t;
                    end else begin
                        held = c;
                    end
                end else if (b > a && b > x && b > thr) begin
                    if (!is_open)
                        open_pulse(c);
                end
            end
            win[0] = win[1];
            win[1] = x;
            if (tick < MAX_TICKS - 1)
                tick++;
            if (last) begin
                if (is_open)
                    close_pulse(t, x);
                if (pend_v)
                    add_record(pend_s, pend_e, pend_p, 0, CNT_SINGLE);
                clear_wire();
            end
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last_of_run = 1'b1;
            foreach (fresh[i])
                due_records.insert(due_records.size(), fresh[i]);
        endfunction

        function void match_record(t_record got);
            t_record want;
            int      wv[6];
            int      gv[6];
            if (due_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record: expected none, got begin %0d finish %0d",
                         $time, got.begin_tick, got.finish_tick);
                return;
            end
            want = due_records.pop_front();
            wv = '{want.begin_tick, want.finish_tick, want.first_peak_tick,
                   want.second_peak_tick, want.peak_count, want.last_of_run};
            gv = '{got.begin_tick, got.finish_tick, got.first_peak_tick,
                   got.second_peak_tick, got.peak_count, got.last_of_run};
            foreach (wv[i]) begin
                if (wv[i] != gv[i]) begin
                    errors++;
                    $display("%0t: %s expected %0d got %0d", $time, field_name[i], wv[i], gv[i]);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_last_sample = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [THR_W-1:0]              i_cfg_wdata = '0;
    logic                          i_stall = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [TICK_OUT_W-1:0]         o_begin_tick;
    logic [TICK_OUT_W-1:0]         o_finish_tick;
    logic [TICK_OUT_W-1:0]         o_first_peak_tick;
    logic [TICK_OUT_W-1:0]         o_second_peak_tick;
    logic [CNT_W-1:0]              o_peak_count;
    logic                          o_last_of_run;

    pulse_book book;
    int        send_idle = 0;
    int        recv_stall = 0;
    logic      hold_off = 1'b0;
    int        thr_now = 0;
    int        items_sent = 0;
    int        cycles = 0;

    pulse_region_finder #(
        .MAX_TICKS  (MAX_TICKS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .i_last_sample     (i_last_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_begin_tick      (o_begin_tick),
        .o_finish_tick     (o_finish_tick),
        .o_first_peak_tick (o_first_peak_tick),
        .o_second_peak_tick(o_second_peak_tick),
        .o_peak_count      (o_peak_count),
        .o_last_of_run     (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            book.match_record({o_begin_tick, o_finish_tick, o_first_peak_tick,
                               o_second_peak_tick, o_peak_count, o_last_of_run});
        i_stall <= hold_off || ($urandom_range(99) < recv_stall);
    end

    task automatic send_sample(input int s, input bit last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s[SAMPLE_BITS-1:0];
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        book.take_sample(s, last);
        items_sent++;
    endtask

    task automatic send_wire(input int samples[$]);
        foreach (samples[i])
            send_sample(samples[i], i == samples.size() - 1);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (book.due_records.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[THR_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        book.thr = v;
        thr_now  = v;
    endtask

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // rising and falling ramps with random peaks, valleys and plateaus
    task automatic send_shaped_wire(input int len);
        int  lvl;
        int  from;
        int  target;
        int  steps;
        int  k;
        int  v;
        bit  rising;
        lvl    = int'($urandom_range(0, 400)) - 200;
        from   = lvl;
        target = lvl;
        rising = 1'b0;
        steps  = 0;
        k      = 0;
        for (int n = 0; n < len; n++) begin
            if (k >= steps) begin
                from   = lvl;
                rising = !rising;
                if (rising) begin
                    if ($urandom_range(9) == 0)
                        target = thr_now - int'($urandom_range(0, 50));
                    else
                        target = thr_now + int'($urandom_range(1, 3000));
                end else begin
                    case ($urandom_range(2))
                        0: target = -int'($urandom_range(0, 4000));
                        1: target = thr_now / 2 + 1 + int'($urandom_range(0, thr_now / 2));
                        default: target = int'($urandom_range(0, thr_now / 2));
                    endcase
                end
                steps = $urandom_range(1, 4);
                k     = 0;
            end
            k++;
            v = from + (target - from) * k / steps;
            if ($urandom_range(9) == 0)
                v = lvl;
            lvl = clamp16(v);
            send_sample(lvl, n == len - 1);
        end
    endtask

    task automatic send_noise_wire(input int len);
        for (int n = 0; n < len; n++)
            send_sample(int'($urandom_range(0, 65535)) - 32768, n == len - 1);
    endtask

    task automatic send_wires(input int n_items);
        int goal;
        int pick;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_shaped_wire($urandom_range(3, 80));
            else if (pick < 95)
                send_noise_wire($urandom_range(3, 40));
            else
                send_noise_wire($urandom_range(1, 2));
        end
    endtask

    task automatic pick_threshold();
        case ($urandom_range(5))
            0: write_threshold(0);
            1: write_threshold(32767);
            2: write_threshold($urandom_range(0, 32767));
            default: write_threshold($urandom_range(0, 4000));
        endcase
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit press);
        int goal;
        send_idle  = s_pct;
        recv_stall = r_pct;
        goal = items_sent + PHASE_ITEMS;
        if (press) begin
            wait_idle();
            write_threshold(1000);
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (400) @(posedge i_clk);
                    hold_off <= 1'b0;
                end
                send_wires(80);
            join
        end
        while (items_sent < goal) begin
            wait_idle();
            pick_threshold();
            send_wires(120);
        end
    endtask

    initial begin
        int bumps[6];
        int s;
        bumps = '{50, 400, 900, 400, 50, -100};
        book = new;
        book.clear_wire();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // threshold at its reset value of zero
        send_wire({32767});
        send_wire({-32768, 0});
        send_wire({-32768, 32767, 10, 20, 15, 30, 5, 1000, -5});
        send_wire({0, 10, 5, 5, 20, 0});
        wait_idle();
        write_threshold(100);
        send_wire({0, 500, 40, 600, 0});
        wait_idle();
        write_threshold(32767);
        send_wire({0, 32767, 0});

        // long wire with widely spaced pulses over low noise
        wait_idle();
        write_threshold(100);
        for (int n = 0; n < LONG_LEN; n++) begin
            if (n % 128 < 6)
                s = bumps[n % 128];
            else
                s = int'($urandom_range(0, 20)) - 10;
            send_sample(s, n == LONG_LEN - 1);
        end

        run_phase(0, 0, 1'b0);
        run_phase(58, 0, 1'b0);
        run_phase(0, 58, 1'b1);
        run_phase(22, 22, 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (book.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
